[rtl/core/mcc_pkg.sv]
// Shared constants, codes and types for the minimum-coin change block.
// Used by mcc_cell, mcc_denoms and the top level; depends on nothing.
package mcc_pkg;

	localparam int MAX_DENOMS = 16;
	localparam int MAX_AMOUNT = 1023;

	localparam int VAL_W  = 10;
	localparam int TAL_W  = 10;
	localparam int DP_W   = 14;
	localparam int INF_COINS = 9999;

	localparam int IDX_W  = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
	localparam int CNT_W  = $clog2(MAX_DENOMS + 1);
	localparam int AMT_W  = $clog2(MAX_AMOUNT + 1);
	localparam int CMP_W  = (VAL_W > AMT_W) ? VAL_W : AMT_W;
	localparam int ADDR_W = IDX_W + AMT_W;
	localparam int RAM_DEPTH = (2 ** IDX_W) * (2 ** AMT_W);

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_UNREACH = 2'd1,
		STAT_INVALID = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_DRAIN,
		S_BT_RD,
		S_BT_EV,
		S_SCAN,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic [AMT_W-1:0] k;
		logic [VAL_W-1:0] d;
		logic [DP_W-1:0]  a;
		logic [DP_W-1:0]  b;
	} cell_in_t;

	typedef struct packed {
		logic [DP_W-1:0] fill;
		logic            take;
	} cell_out_t;

endpackage

[rtl/core/mcc_ram.sv]
// Generic simple RAM: one write port, two registered read ports.
// Stand-alone; no package dependency.
module mcc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr_a,
	input  logic [$clog2(D)-1:0] raddr_b,
	output logic [W-1:0]         rdata_a,
	output logic [W-1:0]         rdata_b
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/core/mcc_cell.sv]
// Shared compare/add unit: one table cell update or one backtrack test.
// Depends on mcc_pkg.
module mcc_cell (
	input  mcc_pkg::cell_in_t  ci,
	output mcc_pkg::cell_out_t co
);

	localparam int CW = mcc_pkg::CMP_W;
	localparam int DW = mcc_pkg::DP_W;

	logic [CW-1:0] kx;
	logic [CW-1:0] dx;
	logic [DW-1:0] b1;
	logic          eq;
	logic          zero;

	assign kx   = CW'(ci.k);
	assign dx   = CW'(ci.d);
	assign b1   = ci.b + DW'(1);
	assign eq   = (kx == dx);
	assign zero = (dx == '0);

	always_comb begin
		if (eq) begin
			co.fill = DW'(1);
		end else if (zero || kx < dx) begin
			co.fill = ci.a;
		end else begin
			co.fill = (b1 < ci.a) ? b1 : ci.a;
		end
		co.take = eq || (!zero && kx > dx && ci.a == b1);
	end

endmodule

[rtl/core/mcc_denoms.sv]
// Sorted denomination list with ordered insert and clear.
// Depends on mcc_pkg.
module mcc_denoms (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic                              add,
	input  logic [mcc_pkg::VAL_W-1:0]         add_value,
	input  logic [mcc_pkg::IDX_W-1:0]         rd_idx,
	output logic [mcc_pkg::VAL_W-1:0]         rd_data,
	output logic [mcc_pkg::CNT_W-1:0]         count
);

	localparam int N = mcc_pkg::MAX_DENOMS;

	logic [mcc_pkg::VAL_W-1:0] list_q [N];
	logic [mcc_pkg::VAL_W-1:0] list_d [N];
	logic [mcc_pkg::CNT_W-1:0] count_q;
	logic [N-1:0]              ins;
	logic                      full;

	assign full    = (int'(count_q) >= N);
	assign count   = count_q;
	assign rd_data = list_q[rd_idx];

	// entries at or past the insert point shift up by one
	for (genvar i = 0; i < N; i++) begin : g_ins
		assign ins[i] = (i >= int'(count_q)) || (list_q[i] > add_value);
		if (i == 0) begin : g_first
			assign list_d[i] = ins[i] ? add_value : list_q[i];
		end else begin : g_rest
			assign list_d[i] = !ins[i] ? list_q[i] :
				(!ins[i-1] ? add_value : list_q[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (add && !full) begin
			count_q <= count_q + mcc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (add && !clear && !full) begin
			for (int i = 0; i < N; i++) begin
				list_q[i] <= list_d[i];
			end
		end
	end

endmodule

[rtl/core/min_coin_change_with_breakdown.sv]
// Minimum-coin change with breakdown: top level, sequencer and result register.
// Clear and add leave the block idle. A query fills the table one cell per cycle
// through the shared cell unit, with a turn state after each row, then backtracks
// with one table read per step and finally scans the tallies for the results.
// One item at a time; ready again once the final result of a query is taken.
// Async active-low reset clears the list count, sequencer, fill valid, backtrack flag, tallies and result valid only.
module min_coin_change_with_breakdown (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    op,
	input  logic [mcc_pkg::VAL_W-1:0]     value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [mcc_pkg::VAL_W-1:0]     denomination,
	output logic [mcc_pkg::TAL_W-1:0]     coin_count,
	output logic [1:0]                    status,
	output logic                          last
);

	localparam int N   = mcc_pkg::MAX_DENOMS;
	localparam int IW  = mcc_pkg::IDX_W;
	localparam int AW  = mcc_pkg::AMT_W;
	localparam int DW  = mcc_pkg::DP_W;
	localparam int VW  = mcc_pkg::VAL_W;
	localparam int TW  = mcc_pkg::TAL_W;
	localparam int CW  = mcc_pkg::CMP_W;
	localparam int CNW = mcc_pkg::CNT_W;

	mcc_pkg::state_t state_q, state_d;

	// query context
	logic [AW-1:0] amt_q;
	logic [IW-1:0] jr_q;      // stored row index (table row j = jr_q + 1)
	logic [AW-1:0] k_q;
	logic          first_q;

	// fill pipeline: read issued in S_FILL, cell written in the next cycle
	logic          fill_v_s1;
	logic [AW-1:0] k_s1;
	logic [DW-1:0] fwd_q;

	logic [TW-1:0] tally_q [N];

	logic                    res_valid_q;
	logic [VW-1:0]           res_den_q;
	logic [TW-1:0]           res_cnt_q;
	mcc_pkg::status_t        res_stat_q;
	logic                    res_last_q;

	// list
	logic [IW-1:0]  den_idx;
	logic [VW-1:0]  d;
	logic [CNW-1:0] den_count;
	logic           list_clear;
	logic           list_add;

	// table memory
	logic [mcc_pkg::ADDR_W-1:0] raddr_a, raddr_b, waddr;
	logic [DW-1:0]              rd_a, rd_b;

	mcc_pkg::cell_in_t  ci;
	mcc_pkg::cell_out_t co;

	// decisions
	logic          acc, res_acc, is_query, q_bad;
	logic [IW-1:0] last_row;
	logic [N-1:0]  mask;
	logic          no_coin, scan_hit, below_any;
	logic          bt_unreach, bt_eq;
	logic [AW-1:0] k_minus_d;

	// result load
	logic                  ld_res;
	logic [VW-1:0]         ld_den;
	logic [TW-1:0]         ld_cnt;
	mcc_pkg::status_t      ld_stat;
	logic                  ld_last;
	logic                  tally_inc;

	assign req_ready    = (state_q == mcc_pkg::S_IDLE);
	assign res_valid    = res_valid_q;
	assign denomination = res_den_q;
	assign coin_count   = res_cnt_q;
	assign status       = res_stat_q;
	assign last         = res_last_q;

	assign acc       = req_valid && req_ready;
	assign res_acc   = res_valid_q && res_ready;
	assign is_query  = (op == mcc_pkg::OP_QUERY);
	assign q_bad     = (int'(value) > mcc_pkg::MAX_AMOUNT) || (den_count == '0);
	assign last_row  = IW'(den_count - CNW'(1));
	assign list_clear = acc && (op == mcc_pkg::OP_CLEAR);
	assign list_add   = acc && (op == mcc_pkg::OP_ADD);

	assign k_minus_d  = AW'(CW'(k_q) - CW'(d));
	assign bt_unreach = first_q && (rd_a >= DW'(mcc_pkg::INF_COINS));
	assign bt_eq      = (CW'(k_q) == CW'(d));

	always_comb begin
		below_any = 1'b0;
		for (int i = 0; i < N; i++) begin
			mask[i] = (tally_q[i] != '0);
			if (i < int'(jr_q)) begin
				below_any = below_any | mask[i];
			end
		end
	end
	assign no_coin  = (mask == '0);
	assign scan_hit = mask[jr_q];

	// an empty breakdown reports the smallest denomination
	assign den_idx = (state_q == mcc_pkg::S_SCAN && no_coin) ? '0 : jr_q;

	mcc_denoms u_denoms (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (list_clear),
		.add       (list_add),
		.add_value (value),
		.rd_idx    (den_idx),
		.rd_data   (d),
		.count     (den_count)
	);

	// port a: row above during fill, current cell during backtrack
	always_comb begin
		if (state_q == mcc_pkg::S_FILL) begin
			raddr_a = {jr_q - IW'(1), k_q};
		end else begin
			raddr_a = {jr_q, k_q};
		end
		raddr_b = {jr_q, k_minus_d};
		waddr   = {jr_q, k_s1};
	end

	mcc_ram #(
		.W (DW),
		.D (mcc_pkg::RAM_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (fill_v_s1),
		.waddr   (waddr),
		.wdata   (co.fill),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Share the cell unit: fill update in the pipeline, test in backtrack.
	// Row 0 reads as unreachable; a unit coin needs the cell just written.
	always_comb begin
		if (state_q == mcc_pkg::S_BT_EV) begin
			ci.k = k_q;
			ci.d = d;
			ci.a = rd_a;
			ci.b = rd_b;
		end else begin
			ci.k = k_s1;
			ci.d = d;
			ci.a = (jr_q == '0) ? DW'(mcc_pkg::INF_COINS) : rd_a;
			ci.b = (d == VW'(1)) ? fwd_q : rd_b;
		end
	end

	mcc_cell u_cell (
		.ci (ci),
		.co (co)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcc_pkg::S_IDLE: begin
				if (acc && is_query) begin
					if (q_bad) begin
						state_d = mcc_pkg::S_WAIT;
					end else if (value == '0) begin
						state_d = mcc_pkg::S_SCAN;
					end else begin
						state_d = mcc_pkg::S_FILL;
					end
				end
			end
			mcc_pkg::S_FILL: begin
				if (k_q == amt_q) begin
					state_d = mcc_pkg::S_DRAIN;
				end
			end
			mcc_pkg::S_DRAIN: begin
				state_d = (jr_q == last_row) ? mcc_pkg::S_BT_RD : mcc_pkg::S_FILL;
			end
			mcc_pkg::S_BT_RD: begin
				state_d = mcc_pkg::S_BT_EV;
			end
			mcc_pkg::S_BT_EV: begin
				if (bt_unreach) begin
					state_d = mcc_pkg::S_WAIT;
				end else if (co.take) begin
					state_d = bt_eq ? mcc_pkg::S_SCAN : mcc_pkg::S_BT_RD;
				end else begin
					state_d = (jr_q == '0) ? mcc_pkg::S_SCAN : mcc_pkg::S_BT_RD;
				end
			end
			mcc_pkg::S_SCAN: begin
				if (no_coin || scan_hit) begin
					state_d = mcc_pkg::S_WAIT;
				end
			end
			mcc_pkg::S_WAIT: begin
				if (res_acc) begin
					state_d = res_last_q ? mcc_pkg::S_IDLE : mcc_pkg::S_SCAN;
				end
			end
			default: begin
				state_d = mcc_pkg::S_IDLE;
			end
		endcase
	end

	// result loads and tally strobe
	always_comb begin
		ld_res    = 1'b0;
		ld_den    = '0;
		ld_cnt    = '0;
		ld_stat   = mcc_pkg::STAT_OK;
		ld_last   = 1'b1;
		tally_inc = 1'b0;
		case (state_q)
			mcc_pkg::S_IDLE: begin
				if (acc && is_query && q_bad) begin
					ld_res  = 1'b1;
					ld_stat = mcc_pkg::STAT_INVALID;
				end
			end
			mcc_pkg::S_BT_EV: begin
				if (bt_unreach) begin
					ld_res  = 1'b1;
					ld_stat = mcc_pkg::STAT_UNREACH;
				end else begin
					tally_inc = co.take;
				end
			end
			mcc_pkg::S_SCAN: begin
				if (no_coin) begin
					ld_res = 1'b1;
					ld_den = d;
				end else if (scan_hit) begin
					ld_res  = 1'b1;
					ld_den  = d;
					ld_cnt  = tally_q[jr_q];
					ld_last = !below_any;
				end
			end
			default: begin
				ld_res = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcc_pkg::S_IDLE;
			fill_v_s1   <= 1'b0;
			res_valid_q <= 1'b0;
			first_q     <= 1'b0;
			for (int i = 0; i < N; i++) begin
				tally_q[i] <= '0;
			end
		end else begin
			state_q   <= state_d;
			fill_v_s1 <= (state_q == mcc_pkg::S_FILL);
			if (ld_res) begin
				res_valid_q <= 1'b1;
			end else if (res_acc) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == mcc_pkg::S_DRAIN) begin
				first_q <= 1'b1;
			end else if (state_q == mcc_pkg::S_BT_EV) begin
				first_q <= 1'b0;
			end
			if (acc && is_query) begin
				for (int i = 0; i < N; i++) begin
					tally_q[i] <= '0;
				end
			end else if (tally_inc && tally_q[jr_q] != '1) begin
				tally_q[jr_q] <= tally_q[jr_q] + TW'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (fill_v_s1) begin
			fwd_q <= co.fill;
		end
		if (ld_res) begin
			res_den_q  <= ld_den;
			res_cnt_q  <= ld_cnt;
			res_stat_q <= ld_stat;
			res_last_q <= ld_last;
		end
		case (state_q)
			mcc_pkg::S_IDLE: begin
				if (acc && is_query) begin
					amt_q <= AW'(value);
					k_q   <= AW'(1);
					jr_q  <= (value == '0) ? last_row : '0;
				end
			end
			mcc_pkg::S_FILL: begin
				k_q <= k_q + AW'(1);
			end
			mcc_pkg::S_DRAIN: begin
				// hold the last row for backtrack, else advance a row
				if (jr_q == last_row) begin
					k_q <= amt_q;
				end else begin
					jr_q <= jr_q + IW'(1);
					k_q  <= AW'(1);
				end
			end
			mcc_pkg::S_BT_EV: begin
				if (!bt_unreach) begin
					if (co.take) begin
						k_q <= k_minus_d;
						if (bt_eq) begin
							jr_q <= last_row;
						end
					end else begin
						jr_q <= (jr_q == '0) ? last_row : jr_q - IW'(1);
					end
				end
			end
			mcc_pkg::S_SCAN: begin
				if (!no_coin && !scan_hit) begin
					jr_q <= jr_q - IW'(1);
				end
			end
			mcc_pkg::S_WAIT: begin
				if (res_acc && !res_last_q) begin
					jr_q <= jr_q - IW'(1);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

`ifndef SYNTH
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !res_valid)
		else $error("request taken while a result is pending");

	a_fill_stage: assert property (@(posedge clk) disable iff (!arst_n)
		fill_v_s1 |-> (state_q == mcc_pkg::S_FILL || state_q == mcc_pkg::S_DRAIN))
		else $error("table write outside fill");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && last) |=> req_ready)
		else $error("not ready after final result");

	a_fault_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != mcc_pkg::STAT_OK) |-> last)
		else $error("fault result not final");
`endif

endmodule
